// ===== rtl/spht_pkg.sv =====
// spht_pkg: shared types, codes and lookup tables for the scene policy hysteresis unit
// no dependencies; imported by spht_decide, scene_policy_hysteresis_unit, spht_checker and tb
`timescale 1ns / 1ps

package spht_pkg;

    localparam int FRAME_BITS = 32;
    localparam int COUNT_BITS = 32;

    // class codes
    localparam logic [2:0] CLASS_NONE  = 3'd0;
    localparam logic [2:0] CLASS_PANIC = 3'd6;

    // mode label codes
    localparam logic [2:0] LABEL_INITIAL = 3'd0;
    localparam logic [2:0] LABEL_UNKNOWN = 3'd6;
    localparam logic [2:0] LABEL_PANIC   = 3'd7;

    // decision reason codes
    localparam logic [2:0] WHY_INITIAL  = 3'd0;
    localparam logic [2:0] WHY_PANIC    = 3'd1;
    localparam logic [2:0] WHY_LOWCONF  = 3'd2;
    localparam logic [2:0] WHY_HIGHCONF = 3'd3;
    localparam logic [2:0] WHY_PIN      = 3'd4;

    // mask mode codes
    localparam logic [1:0] MASK_NONE     = 2'd0;
    localparam logic [1:0] MASK_MOSAIC   = 2'd1;
    localparam logic [1:0] MASK_BLUR     = 2'd2;
    localparam logic [1:0] MASK_BLACKOUT = 2'd3;

    // encode hint codes
    localparam logic [1:0] HINT_BALANCED = 2'd0;
    localparam logic [1:0] HINT_TEXT     = 2'd1;
    localparam logic [1:0] HINT_DETAIL   = 2'd2;
    localparam logic [1:0] HINT_MOTION   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_CONF_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RUN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_SWITCH_GAP     = 2'd2;

    localparam logic [15:0] CONF_THRESHOLD_RST = 16'd32768;
    localparam logic [7:0]  RUN_LENGTH_RST     = 8'd3;
    localparam logic [15:0] SWITCH_GAP_RST     = 16'd150;

    typedef struct packed {
        logic        panic_active;
        logic        panic_source;
        logic [2:0]  label_class;
        logic [2:0]  source_class;
        logic [2:0]  scene_type;
        logic [15:0] confidence;
        logic [31:0] frame_index;
    } item_t;

    typedef struct packed {
        logic [15:0] confidence_threshold;
        logic [7:0]  switch_run_length;
        logic [15:0] min_switch_gap;
    } cfg_t;

    typedef struct packed {
        logic [2:0]            stable_class;
        logic [2:0]            pending_class;
        logic [7:0]            pending_run;
        logic [FRAME_BITS-1:0] last_switch_frame;
        logic                  switch_seen;
        logic [2:0]            held_label;
        logic [2:0]            held_reason;
        logic [COUNT_BITS-1:0] switch_count;
        logic [COUNT_BITS-1:0] low_conf_count;
    } state_t;

    function automatic logic [1:0] label_mask(input logic [2:0] label);
        logic [1:0] m;
        case (label)
            3'd1, 3'd4: m = MASK_MOSAIC;
            3'd2, 3'd3: m = MASK_BLUR;
            3'd5, 3'd7: m = MASK_BLACKOUT;
            default:    m = MASK_NONE;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] label_hint(input logic [2:0] label);
        logic [1:0] h;
        case (label)
            3'd1:    h = HINT_TEXT;
            3'd2:    h = HINT_DETAIL;
            3'd3:    h = HINT_MOTION;
            default: h = HINT_BALANCED;
        endcase
        return h;
    endfunction

    function automatic logic [2:0] scene_to_class(input logic [2:0] scene);
        logic [2:0] c;
        case (scene)
            3'd1, 3'd2, 3'd3, 3'd4, 3'd5: c = scene;
            3'd6:    c = 3'd3;
            default: c = CLASS_NONE;
        endcase
        return c;
    endfunction

    function automatic logic is_class(input logic [2:0] c);
        return (c >= 3'd1) && (c <= 3'd5);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

// ===== rtl/spht_decide.sv =====
// spht_decide: next-state logic for one frame of the hysteresis policy
// depends on spht_pkg for item, configuration and state types
`timescale 1ns / 1ps

module spht_decide (
    input  spht_pkg::item_t  item,
    input  spht_pkg::cfg_t   cfg,
    input  spht_pkg::state_t st,
    output spht_pkg::state_t st_next
);
    import spht_pkg::*;

    logic [2:0]            cls;
    logic [FRAME_BITS-1:0] frame;
    logic [FRAME_BITS-1:0] gap;
    logic [7:0]            run_new;
    logic                  gap_ok;
    logic                  run_ok;

    always_comb begin
        if (is_class(item.label_class)) begin
            cls = item.label_class;
        end else if (is_class(item.source_class)) begin
            cls = item.source_class;
        end else begin
            cls = scene_to_class(item.scene_type);
        end
    end

    assign frame = FRAME_BITS'(item.frame_index);
    assign gap   = frame - st.last_switch_frame;

    always_comb begin
        if (st.pending_class == cls) begin
            run_new = (st.pending_run == 8'hFF) ? st.pending_run : st.pending_run + 8'd1;
        end else begin
            run_new = 8'd1;
        end
    end

    assign gap_ok = !st.switch_seen || (gap >= FRAME_BITS'(cfg.min_switch_gap));
    assign run_ok = run_new >= cfg.switch_run_length;

    always_comb begin
        st_next = st;
        if (item.panic_active || item.panic_source) begin
            if (st.held_label != LABEL_PANIC) begin
                st_next.switch_count      = sat_inc(st.switch_count);
                st_next.last_switch_frame = frame;
                st_next.switch_seen       = 1'b1;
            end
            st_next.held_label    = LABEL_PANIC;
            st_next.held_reason   = WHY_PANIC;
            st_next.stable_class  = CLASS_PANIC;
            st_next.pending_class = CLASS_NONE;
            st_next.pending_run   = 8'd0;
        end else if (item.confidence < cfg.confidence_threshold || cls == CLASS_NONE) begin
            st_next.low_conf_count = sat_inc(st.low_conf_count);
            if (st.stable_class == CLASS_NONE) begin
                st_next.held_label = LABEL_UNKNOWN;
            end
            st_next.held_reason   = WHY_LOWCONF;
            st_next.pending_class = CLASS_NONE;
            st_next.pending_run   = 8'd0;
        end else if (cls == st.stable_class) begin
            st_next.pending_class = CLASS_NONE;
            st_next.pending_run   = 8'd0;
            st_next.held_reason   = WHY_HIGHCONF;
        end else if (gap_ok && run_ok) begin
            if (st.held_label != cls) begin
                st_next.switch_count      = sat_inc(st.switch_count);
                st_next.last_switch_frame = frame;
                st_next.switch_seen       = 1'b1;
            end
            st_next.held_label    = cls;
            st_next.held_reason   = WHY_HIGHCONF;
            st_next.stable_class  = cls;
            st_next.pending_class = CLASS_NONE;
            st_next.pending_run   = 8'd0;
        end else begin
            st_next.pending_class = cls;
            st_next.pending_run   = run_new;
            st_next.held_reason   = WHY_PIN;
        end
    end

endmodule

// ===== rtl/scene_policy_hysteresis_unit.sv =====
// scene_policy_hysteresis_unit: top level with input register, policy state and result register
// depends on spht_pkg and spht_decide
//
//  channel | ports                   | direction | role
//  s_      | s_valid / s_ready       | in        | one frame classifier request
//  m_      | m_valid / m_ready       | out       | one held masking decision per request
//  cfg_    | cfg_valid / cfg_ready   | in        | register write, index and data
//
//  a request waits in the input register, then its decision is registered in the result register;
//  one request accepted every cycle while the result side does not stall
//  the policy state update is a loop from the policy state register through spht_decide
//  a stalled result holds the input register, which keeps accepting while it is free
//  aresetn clears state, counters and valids and restores register defaults
`timescale 1ns / 1ps

module scene_policy_hysteresis_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_panic_active,
    input  logic        s_panic_source,
    input  logic [2:0]  s_label_class,
    input  logic [2:0]  s_source_class,
    input  logic [2:0]  s_scene_type,
    input  logic [15:0] s_confidence,
    input  logic [31:0] s_frame_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_cover_mode,
    output logic [1:0]  m_codec_hint,
    output logic [2:0]  m_policy_label,
    output logic [2:0]  m_decision_reason,
    output logic [2:0]  m_published_class,
    output logic [31:0] m_switch_total,
    output logic [31:0] m_low_conf_total,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import spht_pkg::*;

    cfg_t   cfg_reg;
    item_t  item_reg;
    logic   in_valid_reg;
    state_t st_reg;
    state_t st_next;
    logic   out_valid_reg;
    logic   advance;

    logic [1:0]  mask_reg;
    logic [1:0]  hint_reg;
    logic [2:0]  label_reg;
    logic [2:0]  reason_reg;
    logic [2:0]  class_reg;
    logic [31:0] switch_total_reg;
    logic [31:0] low_conf_total_reg;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.confidence_threshold <= CONF_THRESHOLD_RST;
            cfg_reg.switch_run_length    <= RUN_LENGTH_RST;
            cfg_reg.min_switch_gap       <= SWITCH_GAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CONF_THRESHOLD: cfg_reg.confidence_threshold <= cfg_data;
                REG_RUN_LENGTH:     cfg_reg.switch_run_length    <= cfg_data[7:0];
                REG_SWITCH_GAP:     cfg_reg.min_switch_gap       <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.panic_active <= s_panic_active;
            item_reg.panic_source <= s_panic_source;
            item_reg.label_class  <= s_label_class;
            item_reg.source_class <= s_source_class;
            item_reg.scene_type   <= s_scene_type;
            item_reg.confidence   <= s_confidence;
            item_reg.frame_index  <= s_frame_index;
        end
    end

    spht_decide u_decide (
        .item    (item_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .st_next (st_next)
    );

    // policy state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.stable_class      <= CLASS_NONE;
            st_reg.pending_class     <= CLASS_NONE;
            st_reg.pending_run       <= 8'd0;
            st_reg.last_switch_frame <= '0;
            st_reg.switch_seen       <= 1'b0;
            st_reg.held_label        <= LABEL_INITIAL;
            st_reg.held_reason       <= WHY_INITIAL;
            st_reg.switch_count      <= '0;
            st_reg.low_conf_count    <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mask_reg           <= label_mask(st_next.held_label);
            hint_reg           <= label_hint(st_next.held_label);
            label_reg          <= st_next.held_label;
            reason_reg         <= st_next.held_reason;
            class_reg          <= st_next.stable_class;
            switch_total_reg   <= 32'(st_next.switch_count);
            low_conf_total_reg <= 32'(st_next.low_conf_count);
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_cover_mode      = mask_reg;
    assign m_codec_hint      = hint_reg;
    assign m_policy_label    = label_reg;
    assign m_decision_reason = reason_reg;
    assign m_published_class = class_reg;
    assign m_switch_total    = switch_total_reg;
    assign m_low_conf_total  = low_conf_total_reg;

    // a stable panic class is always shown with the panic label
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.stable_class == CLASS_PANIC |-> st_reg.held_label == LABEL_PANIC)
        else $error("stable panic class without panic label");

    // a pending candidate and its run count are set and cleared together
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.pending_class == CLASS_NONE) == (st_reg.pending_run == 8'd0))
        else $error("pending class and run count disagree");

    // policy state moves only when a request is processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("policy state changed without a request");

    // the switch counter never goes backwards
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> st_reg.switch_count >= $past(st_reg.switch_count))
        else $error("switch counter decreased");

    // a waiting result blocks processing until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule

// ===== bench/spht_checker.sv =====
// spht_checker: bench class codes plus a passive checker that predicts each held decision
// from the accepted requests and the register writes, then compares every result field
// depends on spht_pkg; instantiated beside the unit by tb
`timescale 1ns / 1ps

package spht_bench_pkg;

    localparam logic [2:0] CLS_TEXT      = 3'd1;
    localparam logic [2:0] CLS_SLIDES    = 3'd2;
    localparam logic [2:0] CLS_VIDEO     = 3'd3;
    localparam logic [2:0] CLS_MIXED     = 3'd4;
    localparam logic [2:0] CLS_SENSITIVE = 3'd5;
    localparam logic [2:0] CLS_SPARE_LO  = 3'd6;
    localparam logic [2:0] CLS_SPARE_HI  = 3'd7;

    localparam logic [2:0] SCENE_UNKNOWN = 3'd0;
    localparam logic [2:0] SCENE_GAME    = 3'd6;
    localparam logic [2:0] SCENE_SPARE   = 3'd7;

endpackage

module spht_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_panic_active,
    input  logic        s_panic_source,
    input  logic [2:0]  s_label_class,
    input  logic [2:0]  s_source_class,
    input  logic [2:0]  s_scene_type,
    input  logic [15:0] s_confidence,
    input  logic [31:0] s_frame_index,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_cover_mode,
    input  logic [1:0]  m_codec_hint,
    input  logic [2:0]  m_policy_label,
    input  logic [2:0]  m_decision_reason,
    input  logic [2:0]  m_published_class,
    input  logic [31:0] m_switch_total,
    input  logic [31:0] m_low_conf_total,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    output int          mismatches,
    output int          awaiting
);
    import spht_pkg::*;
    import spht_bench_pkg::*;

    typedef struct packed {
        logic [1:0]  mask;
        logic [1:0]  hint;
        logic [2:0]  label;
        logic [2:0]  reason;
        logic [2:0]  published;
        logic [31:0] switches;
        logic [31:0] doubtful;
    } decision_t;

    decision_t decisions_due[$];

    logic [15:0] conf_floor;
    logic [7:0]  run_needed;
    logic [15:0] gap_needed;

    logic [2:0]  stable_cls;
    logic [2:0]  cand_cls;
    logic [7:0]  cand_run;
    logic [31:0] last_switch;
    logic        switched_once;
    logic [2:0]  held_label;
    logic [2:0]  held_why;
    logic [31:0] switch_cnt;
    logic [31:0] doubt_cnt;
    int          results_seen;

    function automatic logic [2:0] class_of(input item_t f);
        if (f.label_class >= CLS_TEXT && f.label_class <= CLS_SENSITIVE)
            return f.label_class;
        if (f.source_class >= CLS_TEXT && f.source_class <= CLS_SENSITIVE)
            return f.source_class;
        if (f.scene_type == SCENE_GAME)
            return CLS_VIDEO;
        if (f.scene_type >= CLS_TEXT && f.scene_type <= CLS_SENSITIVE)
            return f.scene_type;
        return CLASS_NONE;
    endfunction

    task note_switch(input logic [31:0] frame);
        if (~&switch_cnt) switch_cnt++;
        last_switch = frame;
        switched_once = 1'b1;
    endtask

    task decide(input item_t f, output decision_t d);
        logic [2:0]  cls;
        logic [31:0] gap_seen;
        logic        gap_ok;
        logic        run_ok;
        if (f.panic_active || f.panic_source) begin
            if (held_label != LABEL_PANIC) note_switch(f.frame_index);
            held_label = LABEL_PANIC;
            held_why   = WHY_PANIC;
            stable_cls = CLASS_PANIC;
            cand_cls   = CLASS_NONE;
            cand_run   = '0;
        end else begin
            cls = class_of(f);
            if (f.confidence < conf_floor || cls == CLASS_NONE) begin
                if (~&doubt_cnt) doubt_cnt++;
                if (stable_cls == CLASS_NONE) held_label = LABEL_UNKNOWN;
                held_why = WHY_LOWCONF;
                cand_cls = CLASS_NONE;
                cand_run = '0;
            end else if (cls == stable_cls) begin
                cand_cls = CLASS_NONE;
                cand_run = '0;
                held_why = WHY_HIGHCONF;
            end else begin
                if (cand_cls == cls) begin
                    if (cand_run != 8'hFF) cand_run++;
                end else begin
                    cand_cls = cls;
                    cand_run = 8'd1;
                end
                gap_seen = f.frame_index - last_switch;
                gap_ok   = !switched_once || (gap_seen >= {16'd0, gap_needed});
                run_ok   = cand_run >= run_needed;
                if (gap_ok && run_ok) begin
                    if (held_label != cls) note_switch(f.frame_index);
                    held_label = cls;
                    held_why   = WHY_HIGHCONF;
                    stable_cls = cls;
                    cand_cls   = CLASS_NONE;
                    cand_run   = '0;
                end else begin
                    held_why = WHY_PIN;
                end
            end
        end

        case (held_label)
            CLS_TEXT, CLS_MIXED:        d.mask = MASK_MOSAIC;
            CLS_SLIDES, CLS_VIDEO:      d.mask = MASK_BLUR;
            CLS_SENSITIVE, LABEL_PANIC: d.mask = MASK_BLACKOUT;
            default:                    d.mask = MASK_NONE;
        endcase
        case (held_label)
            CLS_TEXT:   d.hint = HINT_TEXT;
            CLS_SLIDES: d.hint = HINT_DETAIL;
            CLS_VIDEO:  d.hint = HINT_MOTION;
            default:    d.hint = HINT_BALANCED;
        endcase
        d.label     = held_label;
        d.reason    = held_why;
        d.published = stable_cls;
        d.switches  = switch_cnt;
        d.doubtful  = doubt_cnt;
    endtask

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (mismatches < 100)
            $display("result %0d %s: got 0x%0h, expected 0x%0h", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        item_t     f;
        decision_t d;
        decision_t want;
        if (!aresetn) begin
            conf_floor    = CONF_THRESHOLD_RST;
            run_needed    = RUN_LENGTH_RST;
            gap_needed    = SWITCH_GAP_RST;
            stable_cls    = CLASS_NONE;
            cand_cls      = CLASS_NONE;
            cand_run      = '0;
            last_switch   = '0;
            switched_once = 1'b0;
            held_label    = LABEL_INITIAL;
            held_why      = WHY_INITIAL;
            switch_cnt    = '0;
            doubt_cnt     = '0;
            results_seen  = 0;
            mismatches    = 0;
            decisions_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CONF_THRESHOLD: conf_floor = cfg_data;
                    REG_RUN_LENGTH:     run_needed = cfg_data[7:0];
                    REG_SWITCH_GAP:     gap_needed = cfg_data;
                    default:            ;
                endcase
            end
            if (s_valid && s_ready) begin
                f = {s_panic_active, s_panic_source, s_label_class, s_source_class,
                     s_scene_type, s_confidence, s_frame_index};
                decide(f, d);
                decisions_due.push_back(d);
            end
            if (m_valid && m_ready) begin
                if (decisions_due.size() == 0) begin
                    report("result with no request pending", 32'd0, 32'd0);
                end else begin
                    want = decisions_due.pop_front();
                    if (m_cover_mode !== want.mask)
                        report("cover_mode", 32'(m_cover_mode), 32'(want.mask));
                    if (m_codec_hint !== want.hint)
                        report("codec_hint", 32'(m_codec_hint), 32'(want.hint));
                    if (m_policy_label !== want.label)
                        report("policy_label", 32'(m_policy_label), 32'(want.label));
                    if (m_decision_reason !== want.reason)
                        report("decision_reason", 32'(m_decision_reason), 32'(want.reason));
                    if (m_published_class !== want.published)
                        report("published_class", 32'(m_published_class),
                               32'(want.published));
                    if (m_switch_total !== want.switches)
                        report("switch_total", m_switch_total, want.switches);
                    if (m_low_conf_total !== want.doubtful)
                        report("low_conf_total", m_low_conf_total, want.doubtful);
                end
                results_seen++;
            end
        end
        awaiting = decisions_due.size();
    end

endmodule

// ===== bench/tb.sv =====
// tb: clock, reset and request stimulus for scene_policy_hysteresis_unit, with random idling
// on both channels and register phases; verdict taken from spht_checker
// depends on spht_pkg, spht_bench_pkg, spht_checker and the unit
`timescale 1ns / 1ps

module tb;

    import spht_pkg::*;
    import spht_bench_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_panic_active = 1'b0;
    logic        s_panic_source = 1'b0;
    logic [2:0]  s_label_class = '0;
    logic [2:0]  s_source_class = '0;
    logic [2:0]  s_scene_type = '0;
    logic [15:0] s_confidence = '0;
    logic [31:0] s_frame_index = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_cover_mode;
    logic [1:0]  m_codec_hint;
    logic [2:0]  m_policy_label;
    logic [2:0]  m_decision_reason;
    logic [2:0]  m_published_class;
    logic [31:0] m_switch_total;
    logic [31:0] m_low_conf_total;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_CONF_THRESHOLD;
    logic [15:0] cfg_data = '0;

    int          mismatches;
    int          awaiting;
    int          cycles = 0;
    int          hold_off = 0;
    bit          steady = 1'b0;

    logic [15:0] cur_thr = CONF_THRESHOLD_RST;
    logic [7:0]  cur_run = RUN_LENGTH_RST;
    logic [15:0] cur_gap = SWITCH_GAP_RST;
    logic [31:0] frame_now;

    scene_policy_hysteresis_unit DUT (.*);

    spht_checker policy_check (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side stalls drawn per accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_off = 0;
        end else begin
            if (m_valid && m_ready && !steady) hold_off = $urandom_range(0, 4);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task send_frame(input item_t f);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_panic_active, s_panic_source, s_label_class, s_source_class,
         s_scene_type, s_confidence, s_frame_index} <= f;
        do @(posedge aclk); while (!s_ready);
    endtask

    task drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task configure(input logic [15:0] thr, input logic [7:0] run, input logic [15:0] gap);
        drain();
        write_reg(REG_CONF_THRESHOLD, thr);
        write_reg(REG_RUN_LENGTH, {8'd0, run});
        write_reg(REG_SWITCH_GAP, gap);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cur_thr = thr;
        cur_run = run;
        cur_gap = gap;
    endtask

    function automatic logic [2:0] off_class();
        logic [2:0] c;
        do c = 3'($urandom_range(0, 7)); while (c >= CLS_TEXT && c <= CLS_SENSITIVE);
        return c;
    endfunction

    // a well-formed request naming cls by one of the three routes
    function automatic item_t shape(input logic [2:0] cls, input bit doubtful,
                                    input logic [31:0] fidx);
        item_t f;
        f.panic_active = 1'b0;
        f.panic_source = 1'b0;
        f.label_class  = off_class();
        f.source_class = 3'($urandom_range(0, 7));
        f.scene_type   = 3'($urandom_range(0, 7));
        if (cls == CLASS_NONE) begin
            f.source_class = off_class();
            f.scene_type   = $urandom_range(0, 1) ? SCENE_SPARE : SCENE_UNKNOWN;
        end else begin
            case ($urandom_range(0, 2))
                0: f.label_class = cls;
                1: f.source_class = cls;
                default: begin
                    f.source_class = off_class();
                    f.scene_type = (cls == CLS_VIDEO && $urandom_range(0, 1)) ? SCENE_GAME : cls;
                end
            endcase
        end
        if (doubtful && cur_thr != 16'd0)
            f.confidence = 16'($urandom_range(0, cur_thr - 1));
        else
            f.confidence = 16'($urandom_range(cur_thr, 16'hFFFF));
        f.frame_index = fidx;
        return f;
    endfunction

    task wander(input int count);
        int          left;
        int          streak;
        int          roll;
        int          hi;
        logic [2:0]  cls;
        logic [63:0] raw;
        item_t       f;
        left = count;
        while (left > 0) begin
            cls = 3'($urandom_range(CLS_TEXT, CLS_SENSITIVE));
            hi = (cur_run > 6) ? 8 : cur_run + 2;
            streak = $urandom_range(1, hi);
            steady <= ($urandom_range(0, 4) == 0);
            repeat (streak) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    frame_now = $urandom;
                else if (roll < 18)
                    frame_now = frame_now + $urandom_range(cur_gap / 2, cur_gap * 2 + 2);
                else
                    frame_now = frame_now + $urandom_range(0, 3);
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    f = shape(cls, 1'b0, frame_now);
                    f.panic_active = 1'($urandom_range(0, 1));
                    f.panic_source = !f.panic_active || $urandom_range(0, 1);
                end else if (roll < 12) begin
                    f = shape(cls, 1'b1, frame_now);
                end else if (roll < 16) begin
                    f = shape(CLASS_NONE, 1'b0, frame_now);
                end else if (roll < 21) begin
                    raw = {$urandom, $urandom};
                    f = raw[$bits(item_t)-1:0];
                end else begin
                    f = shape(cls, 1'b0, frame_now);
                end
                send_frame(f);
                left--;
            end
        end
        steady <= 1'b0;
    endtask

    // pending run pinned by the gap until it saturates, then released by a long jump
    task linger;
        int n;
        frame_now = $urandom;
        send_frame({1'b1, 1'b0, CLASS_NONE, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, frame_now});
        for (n = 0; n < 262; n++) begin
            frame_now = frame_now + $urandom_range(0, 1);
            send_frame(shape(CLS_SENSITIVE, 1'b0, frame_now));
        end
        frame_now = frame_now + 32'd70000;
        send_frame(shape(CLS_SENSITIVE, 1'b0, frame_now));
        send_frame(shape(CLS_SENSITIVE, 1'b0, frame_now + 32'd1));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: threshold one half, three sightings, gap of 150
        send_frame({1'b0, 1'b0, CLS_TEXT, CLS_TEXT, CLS_TEXT, 16'h0000, 32'd0});
        send_frame({1'b0, 1'b0, CLASS_NONE, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'd1});
        send_frame({1'b0, 1'b0, CLS_SPARE_HI, CLS_SPARE_LO, SCENE_SPARE, 16'hFFFF, 32'd2});
        send_frame({1'b0, 1'b0, CLS_SLIDES, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'd10});
        send_frame({1'b0, 1'b0, CLS_SLIDES, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'd11});
        send_frame({1'b0, 1'b0, CLS_SLIDES, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'd12});
        send_frame({1'b0, 1'b0, CLASS_NONE, CLS_VIDEO, SCENE_UNKNOWN, 16'hFFFF, 32'd13});
        send_frame({1'b0, 1'b0, CLS_SPARE_LO, CLASS_NONE, SCENE_GAME, 16'hFFFF, 32'd14});
        send_frame({1'b0, 1'b0, CLASS_NONE, CLS_SPARE_HI, CLS_VIDEO, 16'hFFFF, 32'd15});
        send_frame({1'b0, 1'b0, CLS_VIDEO, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'd200});
        send_frame({1'b0, 1'b0, CLS_MIXED, CLASS_NONE, SCENE_UNKNOWN, 16'd32767, 32'd201});
        send_frame({1'b0, 1'b0, CLS_VIDEO, CLASS_NONE, SCENE_UNKNOWN, 16'd32768, 32'd202});
        send_frame({1'b1, 1'b0, CLS_TEXT, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'hFFFF_FF00});
        send_frame({1'b0, 1'b1, CLS_TEXT, CLASS_NONE, SCENE_UNKNOWN, 16'h0000, 32'hFFFF_FF01});
        send_frame({1'b0, 1'b0, CLS_TEXT, CLASS_NONE, SCENE_UNKNOWN, 16'h0000, 32'hFFFF_FF02});
        send_frame({1'b1, 1'b1, CLASS_NONE, CLASS_NONE, SCENE_UNKNOWN, 16'h0000, 32'hFFFF_FF02});
        send_frame({1'b0, 1'b0, CLS_SENSITIVE, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'hFFFF_FF03});
        send_frame({1'b0, 1'b0, CLS_SENSITIVE, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'hFFFF_FF04});
        send_frame({1'b0, 1'b0, CLS_SENSITIVE, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'hFFFF_FF05});
        // gap taken across the frame counter wrap
        send_frame({1'b0, 1'b0, CLS_SENSITIVE, CLASS_NONE, SCENE_UNKNOWN, 16'hFFFF, 32'h0000_0100});
        send_frame({1'b0, 1'b0, CLASS_NONE, CLASS_NONE, CLS_TEXT, 16'hFFFF, 32'h0000_0101});
        send_frame({1'b0, 1'b0, CLASS_NONE, CLASS_NONE, CLS_SLIDES, 16'hFFFF, 32'h0000_0102});
        send_frame({1'b0, 1'b0, CLASS_NONE, CLASS_NONE, CLS_MIXED, 16'hFFFF, 32'h0000_0103});
        send_frame({1'b0, 1'b0, CLASS_NONE, CLASS_NONE, CLS_SENSITIVE, 16'h8000, 32'h0000_0104});

        frame_now = $urandom;
        configure(16'($urandom_range(16'h2000, 16'hE000)), 8'd2, 16'd8);
        wander(40);
        drain();
        wander(40);

        configure(16'h0000, 8'd0, 16'd0);
        wander(40);

        configure(16'hFFFF, 8'hFF, 16'hFFFF);
        linger();
        wander(20);

        configure(16'($urandom_range(16'h1000, 16'hF000)), 8'd1, 16'd0);
        wander(40);

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== scene_policy_hysteresis_unit.f =====
rtl/spht_pkg.sv
rtl/spht_decide.sv
rtl/scene_policy_hysteresis_unit.sv
bench/spht_checker.sv
bench/tb.sv
